@@ rtl/b58enc_pkg.sv @@
package b58enc_pkg;

    localparam int MAX_BYTES_DEF   = 32;
    localparam int DIGIT_SLOTS_DEF = 45;
    localparam int OUT_LIMIT       = 45;

    localparam int RADIX   = 58;
    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;
    // carry into a slot never exceeds 256, slot sum never exceeds 256 + 256*57
    localparam int CARRY_W = 9;
    localparam int SUM_W   = 14;
    localparam int LEFT_W  = $clog2(OUT_LIMIT + 1);

    // divide by 58 through a truncated reciprocal, corrected once afterwards
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / RADIX;
    localparam int RECIP_W     = 15;

    localparam logic [RADIX*8-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    localparam logic [CHAR_W-1:0] ONE_CHAR = 7'h31;

    function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] k;
        logic [7:0]         c;
        k = (d >= DIGIT_W'(RADIX)) ? d - DIGIT_W'(RADIX) : d;
        c = ALPHABET[(RADIX - 1 - int'(k)) * 8 +: 8];
        return c[CHAR_W-1:0];
    endfunction

endpackage

@@ rtl/b58enc_if.sv @@
interface b58enc_in_if;
    logic                            valid;
    logic                            ready;
    logic [b58enc_pkg::BYTE_W-1:0]   data_byte;
    logic                            last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b58enc_out_if;
    logic                            valid;
    logic                            ready;
    logic [b58enc_pkg::CHAR_W-1:0]   out_char;
    logic                            last_char;
    logic                            overflow;

    modport source (output valid, output out_char, output last_char, output overflow,
                    input ready);
    modport sink   (input valid, input out_char, input last_char, input overflow,
                    output ready);
endinterface

@@ rtl/b58enc_ram.sv @@
module b58enc_ram #(
    parameter int WIDTH = b58enc_pkg::DIGIT_W,
    parameter int DEPTH = b58enc_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/b58enc_divmod.sv @@
module b58enc_divmod (
    input  logic [b58enc_pkg::SUM_W-1:0]   i_x,
    output logic [b58enc_pkg::CARRY_W-1:0] o_quot,
    output logic [b58enc_pkg::DIGIT_W-1:0] o_rem
);

    localparam int PW = b58enc_pkg::SUM_W + b58enc_pkg::RECIP_W;

    logic [PW-1:0]                    prod;
    logic [b58enc_pkg::CARRY_W-1:0]   q_est;
    logic [b58enc_pkg::SUM_W-1:0]     q_ext;
    logic [b58enc_pkg::SUM_W-1:0]     q_times;
    logic [b58enc_pkg::SUM_W-1:0]     rem_est;

    always_comb begin
        prod    = PW'(i_x) * PW'(b58enc_pkg::RECIP_MUL);
        // estimate is exact or one low
        q_est   = prod[b58enc_pkg::RECIP_SHIFT +: b58enc_pkg::CARRY_W];
        q_ext   = b58enc_pkg::SUM_W'(q_est);
        // times 58 as 64 - 8 + 2
        q_times = (q_ext << 6) - (q_ext << 3) + (q_ext << 1);
        rem_est = i_x - q_times;
        if (rem_est >= b58enc_pkg::SUM_W'(b58enc_pkg::RADIX)) begin
            o_quot = q_est + b58enc_pkg::CARRY_W'(1);
            o_rem  = b58enc_pkg::DIGIT_W'(rem_est - b58enc_pkg::SUM_W'(b58enc_pkg::RADIX));
        end else begin
            o_quot = q_est;
            o_rem  = b58enc_pkg::DIGIT_W'(rem_est);
        end
    end

endmodule

@@ rtl/base58_encoder_unit.sv @@
// a leading zero byte or a dropped byte needs no fold pass; any other byte walks its carry
// through the digit slots of the digit ram, slot by slot, while input is held off
// last byte: scan down for the top nonzero digit, then emit each leading '1' from S_ONES
// and each digit through S_DRD and S_DOUT (single read port of the digit ram)
// reset: synchronous active low, clears control state; the digit ram is not cleared,
// entries at or above the fill count read as zero, so no clearing pass is needed
module base58_encoder_unit #(
    parameter int MAX_BYTES   = b58enc_pkg::MAX_BYTES_DEF,
    parameter int DIGIT_SLOTS = b58enc_pkg::DIGIT_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b58enc_in_if.sink         i_in,
    b58enc_out_if.source      o_out
);

    localparam int AW   = $clog2(DIGIT_SLOTS);
    localparam int CW   = $clog2(DIGIT_SLOTS + 1);
    localparam int BW   = $clog2(MAX_BYTES + 1);
    localparam int TW0  = (BW > CW) ? BW : CW;
    localparam int TW   = ((TW0 > b58enc_pkg::LEFT_W) ? TW0 : b58enc_pkg::LEFT_W) + 1;
    localparam int DW   = b58enc_pkg::DIGIT_W;
    localparam int LW   = b58enc_pkg::LEFT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_FOLD, S_SCAN0, S_SCAN, S_SETUP, S_ONES, S_DRD, S_DOUT
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic [b58enc_pkg::CARRY_W-1:0]  r_carry, n_carry;
    logic [BW-1:0]                   r_zp, n_zp;
    logic [BW-1:0]                   r_bytes, n_bytes;
    logic [BW-1:0]                   r_ones, n_ones;
    logic [LW-1:0]                   r_left, n_left;
    logic                            r_inzp, n_inzp;
    logic                            r_ovf, n_ovf;
    logic                            r_last, n_last;
    logic                            r_out_valid, n_out_valid;
    logic [b58enc_pkg::CHAR_W-1:0]   r_out_char, n_out_char;
    logic                            r_out_last, n_out_last;
    logic                            r_out_ovf, n_out_ovf;

    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [DW-1:0]                   mem_wdata;
    logic                            mem_re;
    logic [AW-1:0]                   mem_raddr;
    logic [DW-1:0]                   mem_rdata;

    logic [DW-1:0]                   fold_digit;
    logic [b58enc_pkg::SUM_W-1:0]    fold_sum;
    logic [b58enc_pkg::CARRY_W-1:0]  div_quot;
    logic [DW-1:0]                   div_rem;

    logic                            in_acc;
    logic                            out_free;
    logic                            fold_go;
    logic [CW-1:0]                   idx_next;
    logic [CW-1:0]                   idx_prev;
    logic [CW-1:0]                   idx_prev2;
    logic [TW-1:0]                   total;

    b58enc_ram #(
        .WIDTH (DW),
        .DEPTH (DIGIT_SLOTS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    b58enc_divmod u_divmod (
        .i_x    (fold_sum),
        .o_quot (div_quot),
        .o_rem  (div_rem)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.out_char  = r_out_char;
    assign o_out.last_char = r_out_last;
    assign o_out.overflow  = r_out_ovf;

    always_comb begin
        in_acc    = i_in.valid && (r_state == S_IDLE);
        out_free  = !r_out_valid || o_out.ready;
        idx_next  = r_idx + CW'(1);
        idx_prev  = r_idx - CW'(1);
        idx_prev2 = r_idx - CW'(2);
        // slots at or above the fill count are read as zero
        fold_digit = (r_idx < r_cnt) ? mem_rdata : '0;
        fold_sum   = b58enc_pkg::SUM_W'(r_carry) + b58enc_pkg::SUM_W'({fold_digit, 8'h00});
        fold_go    = ((r_carry != '0) || (r_idx < r_cnt)) && (r_idx < CW'(DIGIT_SLOTS));
        total      = TW'(r_zp) + TW'(r_idx);

        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_carry     = r_carry;
        n_zp        = r_zp;
        n_bytes     = r_bytes;
        n_ones      = r_ones;
        n_left      = r_left;
        n_inzp      = r_inzp;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = div_rem;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last = i_in.last_byte;
                    if (r_bytes >= BW'(MAX_BYTES)) begin
                        n_ovf = 1'b1;
                        if (i_in.last_byte) begin
                            n_state = S_SCAN0;
                        end
                    end else begin
                        n_bytes = r_bytes + BW'(1);
                        if (r_inzp && (i_in.data_byte == '0)) begin
                            n_zp = r_zp + BW'(1);
                            if (i_in.last_byte) begin
                                n_state = S_SCAN0;
                            end
                        end else begin
                            n_inzp  = 1'b0;
                            n_carry = b58enc_pkg::CARRY_W'(i_in.data_byte);
                            n_idx   = '0;
                            mem_re  = 1'b1;
                            n_state = S_FOLD;
                        end
                    end
                end
            end
            S_FOLD: begin
                if (fold_go) begin
                    mem_we  = 1'b1;
                    n_carry = div_quot;
                    n_idx   = idx_next;
                    // read the next slot ahead while this one is written
                    if (idx_next < CW'(DIGIT_SLOTS)) begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_next[AW-1:0];
                    end
                end else begin
                    if (r_carry != '0) begin
                        n_ovf = 1'b1;
                    end
                    n_cnt   = r_idx;
                    n_state = r_last ? S_SCAN0 : S_IDLE;
                end
            end
            S_SCAN0: begin
                if (r_cnt == '0) begin
                    n_idx   = '0;
                    n_state = S_SETUP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_cnt - CW'(1));
                    n_idx     = r_cnt;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // r_idx is the candidate length, mem_rdata its top digit
                if (mem_rdata != '0) begin
                    n_state = S_SETUP;
                end else if (r_idx == CW'(1)) begin
                    n_idx   = '0;
                    n_state = S_SETUP;
                end else begin
                    n_idx     = idx_prev;
                    mem_re    = 1'b1;
                    mem_raddr = idx_prev2[AW-1:0];
                end
            end
            S_SETUP: begin
                if (total == '0) begin
                    n_zp    = '0;
                    n_bytes = '0;
                    n_cnt   = '0;
                    n_inzp  = 1'b1;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_left  = (total > TW'(b58enc_pkg::OUT_LIMIT)) ?
                              LW'(b58enc_pkg::OUT_LIMIT) : LW'(total);
                    n_ones  = r_zp;
                    n_state = (r_zp == '0) ? S_DRD : S_ONES;
                end
            end
            S_ONES: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = b58enc_pkg::ONE_CHAR;
                    n_out_last  = (r_left == LW'(1));
                    n_out_ovf   = r_ovf;
                    n_left      = r_left - LW'(1);
                    n_ones      = r_ones - BW'(1);
                    if (r_left == LW'(1)) begin
                        n_zp    = '0;
                        n_bytes = '0;
                        n_cnt   = '0;
                        n_inzp  = 1'b1;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else if (r_ones == BW'(1)) begin
                        n_state = S_DRD;
                    end
                end
            end
            S_DRD: begin
                mem_re    = 1'b1;
                mem_raddr = idx_prev[AW-1:0];
                n_state   = S_DOUT;
            end
            S_DOUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = b58enc_pkg::b58_char(mem_rdata);
                    n_out_last  = (r_left == LW'(1));
                    n_out_ovf   = r_ovf;
                    n_left      = r_left - LW'(1);
                    n_idx       = idx_prev;
                    if (r_left == LW'(1)) begin
                        n_zp    = '0;
                        n_bytes = '0;
                        n_cnt   = '0;
                        n_inzp  = 1'b1;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_zp        <= '0;
            r_bytes     <= '0;
            r_ones      <= '0;
            r_left      <= '0;
            r_inzp      <= 1'b1;
            r_ovf       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_zp        <= n_zp;
            r_bytes     <= n_bytes;
            r_ones      <= n_ones;
            r_left      <= n_left;
            r_inzp      <= n_inzp;
            r_ovf       <= n_ovf;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_carry     <= n_carry;
            r_out_char  <= n_out_char;
            r_out_last  <= n_out_last;
            r_out_ovf   <= n_out_ovf;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx <= CW'(DIGIT_SLOTS)) && (r_cnt <= CW'(DIGIT_SLOTS)))
        else $error("digit index beyond store");

    a_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ONES || r_state == S_DOUT || r_state == S_DRD) |-> (r_left != '0))
        else $error("emitting with no characters left");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_wdata < DW'(b58enc_pkg::RADIX)))
        else $error("digit written out of base 58 range");

    a_fold_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> (r_carry <= b58enc_pkg::CARRY_W'(256)))
        else $error("carry out of range");

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    MAX_IN      = b58enc_pkg::MAX_BYTES_DEF;
    localparam int    SLOTS       = b58enc_pkg::DIGIT_SLOTS_DEF;
    localparam int    CYCLE_LIMIT = 400000;
    localparam int    DRAIN_WAIT  = 200;
    localparam string B58_CHARS   =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [b58enc_pkg::BYTE_W-1:0] data;
        logic                          last;
        logic                          hold;
    } t_byte_req;

    typedef struct packed {
        logic [b58enc_pkg::CHAR_W-1:0] code;
        logic                          last;
        logic                          ovf;
    } t_char_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    b58enc_in_if  in_if ();
    b58enc_out_if out_if ();

    base58_encoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    t_byte_req byte_q[$];
    t_char_res chars_due[$];
    int        err_count = 0;
    int        cycle_count = 0;

    // encoder state as the block should hold it
    logic [b58enc_pkg::DIGIT_W-1:0] digit_store [SLOTS];
    int                             zero_run;
    int                             taken;
    int                             in_use;
    bit                             in_prefix;
    bit                             lost;

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic clear_encoder();
        foreach (digit_store[i]) digit_store[i] = '0;
        zero_run  = 0;
        taken     = 0;
        in_use    = 0;
        in_prefix = 1'b1;
        lost      = 1'b0;
    endtask

    task automatic encode_byte(input t_byte_req req);
        int        carry;
        int        i;
        int        top;
        int        k;
        t_char_res msg_chars[$];
        t_char_res c;
        if (taken >= MAX_IN) begin
            lost = 1'b1;
        end else begin
            taken++;
            if (in_prefix && req.data == 0) begin
                zero_run++;
            end else begin
                in_prefix = 1'b0;
                carry = int'(req.data);
                i = 0;
                while ((carry != 0 || i < in_use) && i < SLOTS) begin
                    carry += 256 * int'(digit_store[i]);
                    digit_store[i] = b58enc_pkg::DIGIT_W'(carry % b58enc_pkg::RADIX);
                    carry = carry / b58enc_pkg::RADIX;
                    i++;
                end
                if (carry != 0) lost = 1'b1;
                in_use = i;
            end
        end
        if (!req.last) return;
        for (k = 0; k < zero_run && msg_chars.size() < b58enc_pkg::OUT_LIMIT; k++) begin
            c.code = b58enc_pkg::ONE_CHAR;
            msg_chars.push_back(c);
        end
        top = in_use;
        while (top > 0 && digit_store[top-1] == 0) top--;
        for (k = top - 1; k >= 0 && msg_chars.size() < b58enc_pkg::OUT_LIMIT; k--) begin
            c.code = b58enc_pkg::CHAR_W'(B58_CHARS[digit_store[k] % b58enc_pkg::RADIX]);
            msg_chars.push_back(c);
        end
        foreach (msg_chars[j]) begin
            c = msg_chars[j];
            c.last = (j == msg_chars.size() - 1);
            c.ovf  = lost;
            chars_due.push_back(c);
        end
        clear_encoder();
    endtask

    // request driver
    bit        sending = 1'b0;
    int        gap_left = 0;
    bit        send_calm = 1'b0;
    t_byte_req cur = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sending  = 1'b0;
            gap_left = 0;
            in_if.valid <= 1'b0;
        end else begin
            if (sending && in_if.ready) begin
                encode_byte(cur);
                sending = 1'b0;
                if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
                gap_left = send_calm ? 0 : $urandom_range(0, 7);
            end
            if (!sending) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_q.size() > 0 &&
                             !(byte_q[0].hold && chars_due.size() != 0)) begin
                    cur = byte_q.pop_front();
                    sending = 1'b1;
                end
            end
            in_if.valid     <= sending;
            in_if.data_byte <= cur.data;
            in_if.last_byte <= cur.last;
        end
    end

    // result monitor
    int        stall_left = 0;
    bit        recv_calm = 1'b0;
    t_char_res want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (chars_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected char 0x%0h", out_if.out_char));
                end else begin
                    want = chars_due.pop_front();
                    if (out_if.out_char !== want.code)
                        flag_mismatch($sformatf("out_char 0x%0h, want 0x%0h",
                                                out_if.out_char, want.code));
                    if (out_if.last_char !== want.last)
                        flag_mismatch($sformatf("last_char %b, want %b",
                                                out_if.last_char, want.last));
                    if (out_if.overflow !== want.ovf)
                        flag_mismatch($sformatf("overflow %b, want %b",
                                                out_if.overflow, want.ovf));
                end
                if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
                stall_left = recv_calm ? 0 : $urandom_range(0, 7);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_message(input logic [b58enc_pkg::BYTE_W-1:0] msg[$],
                                 input bit hold);
        t_byte_req r;
        foreach (msg[i]) begin
            r.data = msg[i];
            r.last = (i == msg.size() - 1);
            r.hold = hold && (i == 0);
            byte_q.push_back(r);
        end
    endtask

    function automatic logic [b58enc_pkg::BYTE_W-1:0] any_byte();
        return ($urandom_range(0, 7) == 0) ? '0 :
               b58enc_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // mostly short numbers, with full-size, overflowing and all-zero strings mixed in
    task automatic add_random_message(output int len);
        int                            kind;
        int                            zeros;
        logic [b58enc_pkg::BYTE_W-1:0] msg[$];
        kind = $urandom_range(0, 9);
        unique case (kind)
            6: len = $urandom_range(20, MAX_IN);
            7: len = $urandom_range(MAX_IN + 1, MAX_IN + 4);
            8: len = $urandom_range(1, MAX_IN);
            9: len = $urandom_range(7, MAX_IN - 1);
            default: len = $urandom_range(1, 6);
        endcase
        zeros = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : 0;
        for (int i = 0; i < len; i++) begin
            if (kind == 8 || i < zeros) msg.push_back('0);
            else if (kind == 6) msg.push_back('1);
            else msg.push_back(any_byte());
        end
        queue_message(msg, $urandom_range(0, 7) == 0);
    endtask

    initial begin
        int total;
        int len;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        out_if.ready    = 1'b0;
        clear_encoder();

        // single zero, single max, radix edges, zero prefix, zero after prefix
        queue_message('{8'h00}, 1'b0);
        queue_message('{8'hFF}, 1'b0);
        queue_message('{8'h01}, 1'b1);
        queue_message('{8'h39}, 1'b0);
        queue_message('{8'h3A}, 1'b0);
        queue_message('{8'h00, 8'h00, 8'h3A}, 1'b0);
        queue_message('{8'h00, 8'hFF, 8'h00}, 1'b1);
        queue_message('{8'h80, 8'h00, 8'h00, 8'h01}, 1'b0);
        queue_message('{8'h00, 8'h00}, 1'b0);

        total = byte_q.size();
        while (total < 120) begin
            add_random_message(len);
            total += len;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || sending || chars_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
